[hdl/prc_pkg.sv]
// Package with shared constants and the arctangent table of the point rotation block.
`timescale 1ns / 1ps
package prc_pkg;

  localparam int COORD_WIDTH_DEF  = 16;
  localparam int CORDIC_STEPS_DEF = 24;
  localparam int CNT_W            = 16;
  localparam int UNIT_W           = 32;
  localparam int MOD_W            = 50;
  localparam int MOD_STEPS        = 14;
  localparam int ZW               = 34;

  localparam logic [34:0]       TWO_PI_Q32     = 35'd26986075409;
  localparam logic [29:0]       INV_TWO_PI_Q32 = 30'd683565276;
  localparam logic [31:0]       INV_GAIN_Q32   = 32'd2608131496;
  localparam logic [UNIT_W-1:0] UNIT_RESET     = 32'd429497;
  localparam logic [31:0]       HALF_TURN      = 32'h8000_0000;
  localparam logic [31:0]       QUARTER_TURN   = 32'h4000_0000;

  function automatic logic [31:0] atan_turn(input int i);
    logic [31:0] a;
    unique case (i)
      0:  a = 32'h20000000;
      1:  a = 32'h12E4051E;
      2:  a = 32'h09FB385B;
      3:  a = 32'h051111D4;
      4:  a = 32'h028B0D43;
      5:  a = 32'h0145D7E1;
      6:  a = 32'h00A2F61E;
      7:  a = 32'h00517C55;
      8:  a = 32'h0028BE53;
      9:  a = 32'h00145F2F;
      10: a = 32'h000A2F98;
      11: a = 32'h000517CC;
      12: a = 32'h00028BE6;
      13: a = 32'h000145F3;
      14: a = 32'h0000A2FA;
      15: a = 32'h0000517D;
      16: a = 32'h000028BE;
      17: a = 32'h0000145F;
      18: a = 32'h00000A30;
      19: a = 32'h00000518;
      20: a = 32'h0000028C;
      21: a = 32'h00000146;
      22: a = 32'h000000A3;
      23: a = 32'h00000051;
      24: a = 32'h00000029;
      25: a = 32'h00000014;
      26: a = 32'h0000000A;
      27: a = 32'h00000005;
      28: a = 32'h00000003;
      29: a = 32'h00000001;
      30: a = 32'h00000001;
      default: a = 32'h00000000;
    endcase
    return a;
  endfunction

endpackage

[hdl/prc_front.sv]
// Front stages: differences, angle product, squares, sign folding and sum of squares.
`timescale 1ns / 1ps
module prc_front #(
  parameter int COORD_WIDTH = prc_pkg::COORD_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic signed [COORD_WIDTH-1:0]       point_x,
  input  logic signed [COORD_WIDTH-1:0]       point_y,
  input  logic signed [COORD_WIDTH-1:0]       center_x,
  input  logic signed [COORD_WIDTH-1:0]       center_y,
  input  logic signed [prc_pkg::CNT_W-1:0]    angle_count,
  input  logic        [prc_pkg::UNIT_W-1:0]   angle_unit,
  output logic                                out_valid,
  output logic        [2*COORD_WIDTH+2:0]     sum_sq,
  output logic                                p_neg,
  output logic        [prc_pkg::MOD_W-1:0]    p_abs,
  output logic signed [COORD_WIDTH+11:0]      vec_x,
  output logic signed [COORD_WIDTH+11:0]      vec_y,
  output logic        [31:0]                  phase,
  output logic                                nonzero,
  output logic signed [COORD_WIDTH-1:0]       cx,
  output logic signed [COORD_WIDTH-1:0]       cy
);
  import prc_pkg::*;

  localparam int D  = COORD_WIDTH + 1;
  localparam int SW = 2*COORD_WIDTH + 3;
  localparam int VW = COORD_WIDTH + 12;
  localparam int PW = CNT_W + UNIT_W + 1;

  logic               v1_r, v2_r, v3_r;
  logic signed [D-1:0] dx_r, dy_r;
  logic signed [PW-1:0] p_r;
  logic signed [COORD_WIDTH-1:0] cx1_r, cy1_r, cx2_r, cy2_r, cx3_r, cy3_r;
  logic signed [D-1:0] dx_nxt, dy_nxt;
  logic signed [PW-1:0] p_nxt;
  logic [D-1:0]        ax, ay;
  logic [2*D-1:0]      sqx_r, sqy_r;
  logic                pneg2_r, pneg3_r;
  logic [MOD_W-1:0]    pabs2_r, pabs3_r;
  logic signed [VW-1:0] xi, yi, vx2_r, vy2_r, vx3_r, vy3_r;
  logic [31:0]         ph2_r, ph3_r;
  logic                nz2_r, nz3_r;
  logic [SW-1:0]       sum_r;
  logic [PW-1:0]       pmag;

  assign dx_nxt = D'(point_x) - D'(center_x);
  assign dy_nxt = D'(point_y) - D'(center_y);
  assign p_nxt  = PW'(angle_count) * $signed({1'b0, angle_unit});

  assign ax   = dx_r[D-1] ? D'(-dx_r) : D'(dx_r);
  assign ay   = dy_r[D-1] ? D'(-dy_r) : D'(dy_r);
  assign pmag = p_r[PW-1] ? PW'(-p_r) : PW'(p_r);
  assign xi   = VW'(dx_r) <<< 8;
  assign yi   = VW'(dy_r) <<< 8;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx_r    <= dx_nxt;
      dy_r    <= dy_nxt;
      p_r     <= p_nxt;
      cx1_r   <= center_x;
      cy1_r   <= center_y;
      sqx_r   <= (2*D)'(ax) * (2*D)'(ax);
      sqy_r   <= (2*D)'(ay) * (2*D)'(ay);
      pneg2_r <= p_r[PW-1];
      pabs2_r <= MOD_W'(pmag);
      vx2_r   <= dx_r[D-1] ? -xi : xi;
      vy2_r   <= dx_r[D-1] ? -yi : yi;
      ph2_r   <= dx_r[D-1] ? HALF_TURN : 32'd0;
      nz2_r   <= (dx_r != '0) || (dy_r != '0);
      cx2_r   <= cx1_r;
      cy2_r   <= cy1_r;
      sum_r   <= SW'(sqx_r) + SW'(sqy_r);
      pneg3_r <= pneg2_r;
      pabs3_r <= pabs2_r;
      vx3_r   <= vx2_r;
      vy3_r   <= vy2_r;
      ph3_r   <= ph2_r;
      nz3_r   <= nz2_r;
      cx3_r   <= cx2_r;
      cy3_r   <= cy2_r;
    end
  end

  assign out_valid = v3_r;
  assign sum_sq    = sum_r;
  assign p_neg     = pneg3_r;
  assign p_abs     = pabs3_r;
  assign vec_x     = vx3_r;
  assign vec_y     = vy3_r;
  assign phase     = ph3_r;
  assign nonzero   = nz3_r;
  assign cx        = cx3_r;
  assign cy        = cy3_r;

endmodule

[hdl/prc_solve.sv]
// Parallel pipelines for the integer square root, vectoring CORDIC and angle reduction.
`timescale 1ns / 1ps
module prc_solve #(
  parameter int COORD_WIDTH  = prc_pkg::COORD_WIDTH_DEF,
  parameter int CORDIC_STEPS = prc_pkg::CORDIC_STEPS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en,
  input  logic                               in_valid,
  input  logic        [2*COORD_WIDTH+2:0]    sum_sq,
  input  logic                               p_neg,
  input  logic        [prc_pkg::MOD_W-1:0]   p_abs,
  input  logic signed [COORD_WIDTH+11:0]     vec_x,
  input  logic signed [COORD_WIDTH+11:0]     vec_y,
  input  logic        [31:0]                 phase,
  input  logic                               nonzero,
  input  logic signed [COORD_WIDTH-1:0]      cx,
  input  logic signed [COORD_WIDTH-1:0]      cy,
  output logic                               out_valid,
  output logic        [COORD_WIDTH:0]        radius,
  output logic                               m_neg,
  output logic        [prc_pkg::MOD_W-1:0]   m_rem,
  output logic        [31:0]                 phase_out,
  output logic                               nonzero_out,
  output logic signed [COORD_WIDTH-1:0]      cx_out,
  output logic signed [COORD_WIDTH-1:0]      cy_out
);
  import prc_pkg::*;

  localparam int R  = COORD_WIDTH + 1;
  localparam int SW = 2*COORD_WIDTH + 3;
  localparam int VW = COORD_WIDTH + 12;
  localparam int N1 = (R > CORDIC_STEPS) ? R : CORDIC_STEPS;
  localparam int N  = (N1 > MOD_STEPS) ? N1 : MOD_STEPS;

  logic                    v_a    [0:N];
  logic [SW-1:0]           rem_a  [0:N];
  logic [R-1:0]            root_a [0:N];
  logic signed [VW-1:0]    x_a    [0:N];
  logic signed [VW-1:0]    y_a    [0:N];
  logic [31:0]             ph_a   [0:N];
  logic                    nz_a   [0:N];
  logic                    pn_a   [0:N];
  logic [MOD_W-1:0]        md_a   [0:N];
  logic signed [COORD_WIDTH-1:0] cx_a [0:N];
  logic signed [COORD_WIDTH-1:0] cy_a [0:N];

  assign v_a[0]    = in_valid;
  assign rem_a[0]  = sum_sq;
  assign root_a[0] = '0;
  assign x_a[0]    = vec_x;
  assign y_a[0]    = vec_y;
  assign ph_a[0]   = phase;
  assign nz_a[0]   = nonzero;
  assign pn_a[0]   = p_neg;
  assign md_a[0]   = p_abs;
  assign cx_a[0]   = cx;
  assign cy_a[0]   = cy;

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic                 v_r, nz_r, pn_r;
    logic [SW-1:0]        rem_r, rem_nxt;
    logic [R-1:0]         root_r, root_nxt;
    logic signed [VW-1:0] x_r, y_r, x_nxt, y_nxt;
    logic [31:0]          ph_r, ph_nxt;
    logic [MOD_W-1:0]     md_r, md_nxt;
    logic signed [COORD_WIDTH-1:0] cx_r, cy_r;

    if (k < R) begin : g_sqrt
      localparam int B = R - 1 - k;
      logic [SW-1:0] trial;
      assign trial    = (SW'(root_a[k]) << (B + 1)) + (SW'(1) << (2*B));
      assign rem_nxt  = (rem_a[k] >= trial) ? rem_a[k] - trial : rem_a[k];
      assign root_nxt = (rem_a[k] >= trial) ? (root_a[k] | (R'(1) << B)) : root_a[k];
    end else begin : g_sqrt_pass
      assign rem_nxt  = rem_a[k];
      assign root_nxt = root_a[k];
    end

    if (k < CORDIC_STEPS) begin : g_vec
      localparam logic [31:0] A = atan_turn(k);
      logic signed [VW-1:0] xs, ys;
      assign xs = x_a[k] >>> k;
      assign ys = y_a[k] >>> k;
      assign x_nxt  = y_a[k][VW-1] ? x_a[k] - ys : x_a[k] + ys;
      assign y_nxt  = y_a[k][VW-1] ? y_a[k] + xs : y_a[k] - xs;
      assign ph_nxt = y_a[k][VW-1] ? ph_a[k] - A : ph_a[k] + A;
    end else begin : g_vec_pass
      assign x_nxt  = x_a[k];
      assign y_nxt  = y_a[k];
      assign ph_nxt = ph_a[k];
    end

    if (k < MOD_STEPS) begin : g_mod
      localparam logic [MOD_W-1:0] CJ = MOD_W'(TWO_PI_Q32) << (MOD_STEPS - 1 - k);
      assign md_nxt = (md_a[k] >= CJ) ? md_a[k] - CJ : md_a[k];
    end else begin : g_mod_pass
      assign md_nxt = md_a[k];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r <= 1'b0;
      end else if (en) begin
        v_r <= v_a[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r  <= rem_nxt;
        root_r <= root_nxt;
        x_r    <= x_nxt;
        y_r    <= y_nxt;
        ph_r   <= ph_nxt;
        md_r   <= md_nxt;
        nz_r   <= nz_a[k];
        pn_r   <= pn_a[k];
        cx_r   <= cx_a[k];
        cy_r   <= cy_a[k];
      end
    end

    assign v_a[k+1]    = v_r;
    assign rem_a[k+1]  = rem_r;
    assign root_a[k+1] = root_r;
    assign x_a[k+1]    = x_r;
    assign y_a[k+1]    = y_r;
    assign ph_a[k+1]   = ph_r;
    assign md_a[k+1]   = md_r;
    assign nz_a[k+1]   = nz_r;
    assign pn_a[k+1]   = pn_r;
    assign cx_a[k+1]   = cx_r;
    assign cy_a[k+1]   = cy_r;
  end

  assign out_valid   = v_a[N];
  assign radius      = root_a[N];
  assign m_neg       = pn_a[N];
  assign m_rem       = md_a[N];
  assign phase_out   = ph_a[N];
  assign nonzero_out = nz_a[N];
  assign cx_out      = cx_a[N];
  assign cy_out      = cy_a[N];

endmodule

[hdl/prc_rotate.sv]
// Turn conversion, start vector scaling, rotation CORDIC and final rounding with clipping.
`timescale 1ns / 1ps
module prc_rotate #(
  parameter int COORD_WIDTH  = prc_pkg::COORD_WIDTH_DEF,
  parameter int CORDIC_STEPS = prc_pkg::CORDIC_STEPS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en,
  input  logic                               in_valid,
  input  logic        [COORD_WIDTH:0]        radius,
  input  logic                               m_neg,
  input  logic        [prc_pkg::MOD_W-1:0]   m_rem,
  input  logic        [31:0]                 phase,
  input  logic                               nonzero,
  input  logic signed [COORD_WIDTH-1:0]      cx,
  input  logic signed [COORD_WIDTH-1:0]      cy,
  output logic                               out_valid,
  output logic signed [COORD_WIDTH-1:0]      rotated_x,
  output logic signed [COORD_WIDTH-1:0]      rotated_y,
  output logic        [COORD_WIDTH:0]        radius_out,
  output logic                               clipped
);
  import prc_pkg::*;

  localparam int R  = COORD_WIDTH + 1;
  localparam int VW = COORD_WIDTH + 12;
  localparam logic signed [VW:0] CMAX = (VW+1)'((1 << (COORD_WIDTH - 1)) - 1);
  localparam logic signed [VW:0] CMIN = -CMAX - (VW+1)'(1);

  logic        v1_r, v2_r, v3_r, v4_r, vo_r;
  logic [34:0] m_r;
  logic [31:0] ph1_r, ph2_r, ph3_r;
  logic [R+31:0] prod_r;
  logic [46:0] mlo_r;
  logic [47:0] mhi_r;
  logic [R+8:0] x0_r, x0b_r;
  logic [R+32:0] prod_rnd;
  logic [65:0] tsum;
  logic [31:0] turn_r, total, total_adj;
  logic        qflip;
  logic [R-1:0] rad1_r, rad2_r, rad3_r, rad4_r;
  logic signed [COORD_WIDTH-1:0] cx1_r, cy1_r, cx2_r, cy2_r, cx3_r, cy3_r, cx4_r, cy4_r;
  logic signed [VW-1:0] x4_r, x0s;
  logic signed [ZW-1:0] z4_r;

  assign prod_rnd  = (R+33)'(prod_r) + (R+33)'(32'h0080_0000);
  assign tsum      = 66'({mhi_r, 17'b0}) + 66'(mlo_r) + 66'(HALF_TURN);
  assign total     = ph3_r + turn_r;
  assign qflip     = total[31] ^ total[30];
  assign total_adj = qflip ? total ^ HALF_TURN : total;
  assign x0s       = VW'(x0b_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_r    <= (m_neg && (m_rem != '0)) ? TWO_PI_Q32 - 35'(m_rem) : 35'(m_rem);
      ph1_r  <= nonzero ? phase : 32'd0;
      prod_r <= (R+32)'(radius) * (R+32)'(INV_GAIN_Q32);
      rad1_r <= radius;
      cx1_r  <= cx;
      cy1_r  <= cy;
      mlo_r  <= 47'(m_r[16:0]) * 47'(INV_TWO_PI_Q32);
      mhi_r  <= 48'(m_r[34:17]) * 48'(INV_TWO_PI_Q32);
      x0_r   <= prod_rnd[R+32:24];
      ph2_r  <= ph1_r;
      rad2_r <= rad1_r;
      cx2_r  <= cx1_r;
      cy2_r  <= cy1_r;
      turn_r <= tsum[63:32];
      x0b_r  <= x0_r;
      ph3_r  <= ph2_r;
      rad3_r <= rad2_r;
      cx3_r  <= cx2_r;
      cy3_r  <= cy2_r;
      x4_r   <= qflip ? -x0s : x0s;
      z4_r   <= ZW'($signed(total_adj));
      rad4_r <= rad3_r;
      cx4_r  <= cx3_r;
      cy4_r  <= cy3_r;
    end
  end

  logic                 v_a  [0:CORDIC_STEPS];
  logic signed [VW-1:0] x_a  [0:CORDIC_STEPS];
  logic signed [VW-1:0] y_a  [0:CORDIC_STEPS];
  logic signed [ZW-1:0] z_a  [0:CORDIC_STEPS];
  logic [R-1:0]         r_a  [0:CORDIC_STEPS];
  logic signed [COORD_WIDTH-1:0] cx_a [0:CORDIC_STEPS];
  logic signed [COORD_WIDTH-1:0] cy_a [0:CORDIC_STEPS];

  assign v_a[0]  = v4_r;
  assign x_a[0]  = x4_r;
  assign y_a[0]  = '0;
  assign z_a[0]  = z4_r;
  assign r_a[0]  = rad4_r;
  assign cx_a[0] = cx4_r;
  assign cy_a[0] = cy4_r;

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_rot
    localparam logic signed [ZW-1:0] A = $signed(ZW'(atan_turn(k)));
    logic                 v_r;
    logic signed [VW-1:0] x_r, y_r, xs, ys;
    logic signed [ZW-1:0] z_r;
    logic [R-1:0]         r_r;
    logic signed [COORD_WIDTH-1:0] cx_r, cy_r;

    assign xs = x_a[k] >>> k;
    assign ys = y_a[k] >>> k;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r <= 1'b0;
      end else if (en) begin
        v_r <= v_a[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r  <= z_a[k][ZW-1] ? x_a[k] + ys : x_a[k] - ys;
        y_r  <= z_a[k][ZW-1] ? y_a[k] - xs : y_a[k] + xs;
        z_r  <= z_a[k][ZW-1] ? z_a[k] + A : z_a[k] - A;
        r_r  <= r_a[k];
        cx_r <= cx_a[k];
        cy_r <= cy_a[k];
      end
    end

    assign v_a[k+1]  = v_r;
    assign x_a[k+1]  = x_r;
    assign y_a[k+1]  = y_r;
    assign z_a[k+1]  = z_r;
    assign r_a[k+1]  = r_r;
    assign cx_a[k+1] = cx_r;
    assign cy_a[k+1] = cy_r;
  end

  logic signed [VW:0] fx, fy;
  logic signed [VW:0] ox_nxt, oy_nxt;
  logic               clip_nxt;
  logic signed [COORD_WIDTH-1:0] ox_r, oy_r;
  logic [R-1:0]       rad_r;
  logic               clip_r;

  assign fx = (VW+1)'(cx_a[CORDIC_STEPS]) +
              (((VW+1)'(x_a[CORDIC_STEPS]) + (VW+1)'(255)) >>> 8);
  assign fy = (VW+1)'(cy_a[CORDIC_STEPS]) +
              (((VW+1)'(y_a[CORDIC_STEPS]) + (VW+1)'(255)) >>> 8);

  always_comb begin
    clip_nxt = 1'b0;
    ox_nxt   = fx;
    oy_nxt   = fy;
    if (fx > CMAX) begin
      ox_nxt   = CMAX;
      clip_nxt = 1'b1;
    end else if (fx < CMIN) begin
      ox_nxt   = CMIN;
      clip_nxt = 1'b1;
    end
    if (fy > CMAX) begin
      oy_nxt   = CMAX;
      clip_nxt = 1'b1;
    end else if (fy < CMIN) begin
      oy_nxt   = CMIN;
      clip_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else if (en) begin
      vo_r <= v_a[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ox_r   <= COORD_WIDTH'(ox_nxt);
      oy_r   <= COORD_WIDTH'(oy_nxt);
      rad_r  <= r_a[CORDIC_STEPS];
      clip_r <= clip_nxt;
    end
  end

  assign out_valid  = vo_r;
  assign rotated_x  = ox_r;
  assign rotated_y  = oy_r;
  assign radius_out = rad_r;
  assign clipped    = clip_r;

endmodule

[hdl/point_rotation_about_center_core.sv]
// Top level of the point rotation block: stream ports, angle unit register and pipeline.
`timescale 1ns / 1ps
// Rotates a point about a center by angle_count times the configured angle unit. The block
// is a fully pipelined datapath that takes one transaction per clock cycle while the result
// is taken or no result is waiting; the depth of the pipeline is set by the square root,
// vectoring and rotation CORDIC stage chains.
// When the result is not taken the whole pipeline holds and in_tready falls.
module point_rotation_about_center_core #(
  parameter int COORD_WIDTH  = prc_pkg::COORD_WIDTH_DEF,
  parameter int CORDIC_STEPS = prc_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_we,
  input  logic [prc_pkg::UNIT_W-1:0]             cfg_wdata,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // point_x, point_y, center_x, center_y, angle_count, zero fill.
  input  logic [((4*COORD_WIDTH+prc_pkg::CNT_W+7)/8)*8-1:0] in_tdata,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // rotated_x, rotated_y, radius, zero fill.
  output logic [((3*COORD_WIDTH+1+7)/8)*8-1:0]   out_tdata,
  // clipped.
  output logic                                   out_tuser
);
  import prc_pkg::*;

  localparam int CW  = COORD_WIDTH;
  localparam int OW  = ((3*CW + 1 + 7) / 8) * 8;

  logic [UNIT_W-1:0] angle_unit_r;
  logic              en;

  logic              f_v, f_pneg, f_nz;
  logic [2*CW+2:0]   f_sum;
  logic [MOD_W-1:0]  f_pabs;
  logic signed [CW+11:0] f_vx, f_vy;
  logic [31:0]       f_ph;
  logic signed [CW-1:0] f_cx, f_cy;

  logic              s_v, s_mneg, s_nz;
  logic [CW:0]       s_rad;
  logic [MOD_W-1:0]  s_mrem;
  logic [31:0]       s_ph;
  logic signed [CW-1:0] s_cx, s_cy;

  logic signed [CW-1:0] rot_x, rot_y;
  logic [CW:0]       rad_o;
  logic              clip_o;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_unit_r <= UNIT_RESET;
    end else if (cfg_we) begin
      angle_unit_r <= cfg_wdata;
    end
  end

  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  prc_front #(.COORD_WIDTH(CW)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_valid    (in_tvalid),
    .point_x     (in_tdata[CW-1:0]),
    .point_y     (in_tdata[2*CW-1:CW]),
    .center_x    (in_tdata[3*CW-1:2*CW]),
    .center_y    (in_tdata[4*CW-1:3*CW]),
    .angle_count (in_tdata[4*CW+CNT_W-1:4*CW]),
    .angle_unit  (angle_unit_r),
    .out_valid   (f_v),
    .sum_sq      (f_sum),
    .p_neg       (f_pneg),
    .p_abs       (f_pabs),
    .vec_x       (f_vx),
    .vec_y       (f_vy),
    .phase       (f_ph),
    .nonzero     (f_nz),
    .cx          (f_cx),
    .cy          (f_cy)
  );

  prc_solve #(.COORD_WIDTH(CW), .CORDIC_STEPS(CORDIC_STEPS)) u_solve (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_valid    (f_v),
    .sum_sq      (f_sum),
    .p_neg       (f_pneg),
    .p_abs       (f_pabs),
    .vec_x       (f_vx),
    .vec_y       (f_vy),
    .phase       (f_ph),
    .nonzero     (f_nz),
    .cx          (f_cx),
    .cy          (f_cy),
    .out_valid   (s_v),
    .radius      (s_rad),
    .m_neg       (s_mneg),
    .m_rem       (s_mrem),
    .phase_out   (s_ph),
    .nonzero_out (s_nz),
    .cx_out      (s_cx),
    .cy_out      (s_cy)
  );

  prc_rotate #(.COORD_WIDTH(CW), .CORDIC_STEPS(CORDIC_STEPS)) u_rotate (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_valid    (s_v),
    .radius      (s_rad),
    .m_neg       (s_mneg),
    .m_rem       (s_mrem),
    .phase       (s_ph),
    .nonzero     (s_nz),
    .cx          (s_cx),
    .cy          (s_cy),
    .out_valid   (out_tvalid),
    .rotated_x   (rot_x),
    .rotated_y   (rot_y),
    .radius_out  (rad_o),
    .clipped     (clip_o)
  );

  assign out_tdata = OW'({rad_o, rot_y, rot_x});
  assign out_tuser = clip_o;

  localparam logic [CW-1:0] CMAX_O = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] CMIN_O = {1'b1, {(CW-1){1'b0}}};

  a_clip_at_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> (rot_x == CMAX_O) || (rot_x == CMIN_O) ||
                                (rot_y == CMAX_O) || (rot_y == CMIN_O))
    else $error("clipped flag set without a coordinate at a range bound");

  a_zero_radius_no_clip: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (rad_o == '0) |-> !out_tuser)
    else $error("clipped flag set for a point at the center");

endmodule
